// ===== rtl/cldf_pkg.sv =====
// Package: shared constants and result type for the frame deframer.
`default_nettype none
package cldf_pkg;

   localparam logic [7:0]  SYNC_LAST    = 8'hBB;
   localparam logic [23:0] SYNC_HEAD    = 24'h5566AA;
   localparam logic [7:0]  CMD_RECORD   = 8'h81;
   localparam logic [7:0]  CMD_RES      = 8'h83;
   localparam logic [7:0]  CMD_CAMERA   = 8'h94;
   localparam logic [4:0]  POS_START    = 5'd4;
   localparam logic [4:0]  POS_BODY     = 5'd16;
   localparam logic [4:0]  POS_LIMIT    = 5'd20;
   localparam logic [32:0] REM_AFTER_LEN = 33'd11;

   typedef struct packed {
      logic [7:0]         command_id;
      logic [7:0]         control_byte;
      logic [15:0]        sequence_number;
      logic [31:0]        payload_length;
      logic [31:0]        header_check;
      logic [31:0]        frame_check;
      logic               recording_flag;
      logic               recording_changed;
      logic signed [15:0] video_width;
      logic signed [15:0] video_height;
      logic signed [7:0]  camera_kind;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/cldf_sync.sv =====
// Sync hunter: sliding three-byte window that detects 55 66 AA BB.
`default_nettype none
module cldf_sync
   import cldf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic       clear,
   input  wire logic [7:0] rx_byte,
   output logic            hit
);

   logic [23:0] window_ff, window_in;
   logic [1:0]  fill_ff, fill_in;

   assign hit = (fill_ff == 2'd3) && (window_ff == SYNC_HEAD) && (rx_byte == SYNC_LAST);

   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (clear || (take && hit)) begin
         window_in = '0;
         fill_in   = '0;
      end else if (take) begin
         window_in = {window_ff[15:0], rx_byte};
         if (fill_ff != 2'd3) begin
            fill_in = fill_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/cldf_parse.sv =====
// Frame parser: header capture, byte counting and command effects.
`default_nettype none
module cldf_parse
   import cldf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   input  wire logic       hit,
   output logic            in_frame,
   output logic            done,
   output result_type      result
);

   logic        in_frame_ff, in_frame_in;
   logic [4:0]  pos_ff, pos_in;
   logic [32:0] rem_ff, rem_in;
   logic [7:0]  control_ff, control_in;
   logic [31:0] length_ff, length_in;
   logic [15:0] sequence_ff, sequence_in;
   logic [7:0]  command_ff, command_in;
   logic [31:0] hcheck_ff, hcheck_in;
   logic [31:0] tcheck_ff, tcheck_in;
   logic [31:0] early_ff, early_in;
   logic        record_ff, record_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  kind_ff, kind_in;
   logic        step;
   logic        rec_now;
   logic        changed;
   logic [1:0]  tlane;

   assign in_frame = in_frame_ff;
   assign step     = accept && in_frame_ff;
   assign done     = step && (pos_ff > 5'd8) && (rem_ff == 33'd1);
   assign tlane    = 2'(3'd4 - rem_ff[2:0]);

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      rem_in      = rem_ff;
      control_in  = control_ff;
      length_in   = length_ff;
      sequence_in = sequence_ff;
      command_in  = command_ff;
      hcheck_in   = hcheck_ff;
      tcheck_in   = tcheck_ff;
      early_in    = early_ff;
      record_in   = record_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      kind_in     = kind_ff;
      changed     = 1'b0;
      rec_now     = 1'b0;
      if (step) begin
         case (pos_ff)
            5'd4:  control_in         = rx_byte;
            5'd5:  length_in[7:0]     = rx_byte;
            5'd6:  length_in[15:8]    = rx_byte;
            5'd7:  length_in[23:16]   = rx_byte;
            5'd8:  length_in[31:24]   = rx_byte;
            5'd9:  sequence_in[7:0]   = rx_byte;
            5'd10: sequence_in[15:8]  = rx_byte;
            5'd11: command_in         = rx_byte;
            5'd12: hcheck_in[7:0]     = rx_byte;
            5'd13: hcheck_in[15:8]    = rx_byte;
            5'd14: hcheck_in[23:16]   = rx_byte;
            5'd15: hcheck_in[31:24]   = rx_byte;
            5'd16: early_in[7:0]      = rx_byte;
            5'd17: early_in[15:8]     = rx_byte;
            5'd18: early_in[23:16]    = rx_byte;
            5'd19: early_in[31:24]    = rx_byte;
            default: ;
         endcase
         if ((pos_ff >= POS_BODY) && (rem_ff != 33'd0) && (rem_ff <= 33'd4)) begin
            case (tlane)
               2'd0:    tcheck_in[7:0]   = rx_byte;
               2'd1:    tcheck_in[15:8]  = rx_byte;
               2'd2:    tcheck_in[23:16] = rx_byte;
               default: tcheck_in[31:24] = rx_byte;
            endcase
         end
         if (pos_ff == 5'd8) begin
            rem_in = {1'b0, rx_byte, length_ff[23:0]} + REM_AFTER_LEN;
         end else if (pos_ff > 5'd8) begin
            rem_in = rem_ff - 33'd1;
         end
         if (pos_ff < POS_LIMIT) begin
            pos_in = pos_ff + 5'd1;
         end
         if (done) begin
            in_frame_in = 1'b0;
            pos_in      = '0;
            case (command_ff)
               CMD_RECORD: begin
                  rec_now   = (early_in[7:0] != 8'd0);
                  changed   = (rec_now != record_ff);
                  record_in = rec_now;
               end
               CMD_RES: begin
                  if (length_ff >= 32'd2) begin
                     width_in  = early_in[15:0];
                     height_in = early_in[31:16];
                  end
               end
               CMD_CAMERA: begin
                  if (length_ff != 32'd0) begin
                     kind_in = early_in[7:0];
                  end
               end
               default: ;
            endcase
         end
      end else if (accept && hit) begin
         in_frame_in = 1'b1;
         pos_in      = POS_START;
      end
   end

   always_comb begin
      result.command_id        = command_in;
      result.control_byte      = control_in;
      result.sequence_number   = sequence_in;
      result.payload_length    = length_in;
      result.header_check      = hcheck_in;
      result.frame_check       = tcheck_in;
      result.recording_flag    = record_in;
      result.recording_changed = changed;
      result.video_width       = width_in;
      result.video_height      = height_in;
      result.camera_kind       = kind_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         rem_ff      <= '0;
         control_ff  <= '0;
         length_ff   <= '0;
         sequence_ff <= '0;
         command_ff  <= '0;
         hcheck_ff   <= '0;
         tcheck_ff   <= '0;
         early_ff    <= '0;
         record_ff   <= 1'b0;
         width_ff    <= '0;
         height_ff   <= '0;
         kind_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         rem_ff      <= rem_in;
         control_ff  <= control_in;
         length_ff   <= length_in;
         sequence_ff <= sequence_in;
         command_ff  <= command_in;
         hcheck_ff   <= hcheck_in;
         tcheck_ff   <= tcheck_in;
         early_ff    <= early_in;
         record_ff   <= record_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         kind_ff     <= kind_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/camera_link_frame_deframer.sv =====
// Top level: sync-word, length-prefixed frame deframer with registered result.
// Usage:
//   req_ channel carries one received byte per transfer (req_rx_byte).
//   rsp_ channel carries one result per completed frame, on the transfer of
//   the frame's last byte (a frame is 20 + length bytes, sync word included).
//   Bytes outside a frame produce no result; sync inside a frame is ignored.
// Latency: the result is valid in the cycle after the last byte's transfer.
// Throughput: one byte per cycle while not stalled; the per-byte update is a
//   single pass of logic between the state registers and the result register.
// Stall: while a result waits with rsp_stall high, req_stall is raised;
//   otherwise bytes are taken every cycle, also while a result is leaving.
// Reset: synchronous, active high; clears the sync window, frame counters,
//   header fields and the kept recording, resolution and camera values.
`default_nettype none
module camera_link_frame_deframer
   import cldf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_rx_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_command_id,
   output logic [7:0]        rsp_control_byte,
   output logic [15:0]       rsp_sequence_number,
   output logic [31:0]       rsp_payload_length,
   output logic [31:0]       rsp_header_check,
   output logic [31:0]       rsp_frame_check,
   output logic              rsp_recording_flag,
   output logic              rsp_recording_changed,
   output logic signed [15:0] rsp_video_width,
   output logic signed [15:0] rsp_video_height,
   output logic signed [7:0] rsp_camera_kind
);

   logic       accept;
   logic       hit;
   logic       in_frame;
   logic       done;
   result_type result;
   result_type result_ff;
   logic       valid_ff, valid_in;

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   cldf_sync u_sync (
      .clock   (clock),
      .reset   (reset),
      .take    (accept && !in_frame),
      .clear   (done),
      .rx_byte (req_rx_byte),
      .hit     (hit)
   );

   cldf_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .hit      (hit),
      .in_frame (in_frame),
      .done     (done),
      .result   (result)
   );

   always_comb begin
      valid_in = valid_ff;
      if (done) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (done) begin
         result_ff <= result;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_command_id        = result_ff.command_id;
   assign rsp_control_byte      = result_ff.control_byte;
   assign rsp_sequence_number   = result_ff.sequence_number;
   assign rsp_payload_length    = result_ff.payload_length;
   assign rsp_header_check      = result_ff.header_check;
   assign rsp_frame_check       = result_ff.frame_check;
   assign rsp_recording_flag    = result_ff.recording_flag;
   assign rsp_recording_changed = result_ff.recording_changed;
   assign rsp_video_width       = result_ff.video_width;
   assign rsp_video_height      = result_ff.video_height;
   assign rsp_camera_kind       = result_ff.camera_kind;

endmodule
`default_nettype wire
